FILE: hdl/third_order_iir_plant_model_defines.svh
// Assertion macros for the third-order IIR plant model checker.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef THIRD_ORDER_IIR_PLANT_MODEL_DEFINES_SVH
`define THIRD_ORDER_IIR_PLANT_MODEL_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define TIOPM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TIOPM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tiopm_pkg.sv
// Shared types, widths and constants of the third-order IIR plant model.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package tiopm_pkg;

    localparam int FILTER_ORDER = 3;
    localparam int NUM_REGS     = 6;

    localparam int COEF_W    = 18;
    localparam int SAMPLE_W  = 32;
    localparam int STATE_W   = 48;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int RND_SHIFT = 14;
    localparam int RND_W     = PROD_W - RND_SHIFT;
    localparam int ACC_W     = STATE_W + 1;
    localparam int DIFF_W    = STATE_W + 2;

    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam int TAP_W     = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
    localparam int K_W       = $clog2(FILTER_ORDER + 1);

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [RND_W-1:0]    rnd_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [TAP_W-1:0]           tap_t;
    typedef logic [K_W-1:0]             k_t;
    typedef coef_t [NUM_REGS-1:0]       coef_bank_t;

    // Register indexes on the configuration port.
    localparam cfg_idx_t REG_B0 = 3'd0;
    localparam cfg_idx_t REG_B1 = 3'd1;
    localparam cfg_idx_t REG_B2 = 3'd2;
    localparam cfg_idx_t REG_A1 = 3'd3;
    localparam cfg_idx_t REG_A2 = 3'd4;
    localparam cfg_idx_t REG_A3 = 3'd5;

    // Highest index first: a3, a2, a1, b2, b1, b0.
    localparam coef_bank_t COEF_RESET = '{
        -18'sd8684, 18'sd30310, -18'sd37519, -18'sd1114, 18'sd164, 18'sd1475
    };

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam state_t  STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam state_t  STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};

    // Operand select of the shared multiplier.
    typedef logic [1:0] opsel_t;
    localparam opsel_t OPS_IN = 2'd0;
    localparam opsel_t OPS_X  = 2'd1;
    localparam opsel_t OPS_Y  = 2'd2;

    typedef struct packed {
        logic   clear;
        logic   load_x;
        logic   write_y;
        logic   write_acc;
        logic   write_state;
        logic   mul_en;
        opsel_t op_sel;
        logic   coef_is_a;
        k_t     coef_k;
        tap_t   tap;
        logic   last_tap;
    } ctrl_t;

endpackage

FILE: hdl/tiopm_sample_if.sv
// Input channel of the plant model: a command and one Q16.16 sample per item.
// Depends on tiopm_pkg.
interface tiopm_sample_if import tiopm_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    command;
    sample_t sample_in;

    modport source (output valid, output command, output sample_in, input ready);
    modport sink (input valid, input command, input sample_in, output ready);
endinterface

FILE: hdl/tiopm_result_if.sv
// Output channel of the plant model: one saturated Q16.16 sample per item.
// Depends on tiopm_pkg.
interface tiopm_result_if import tiopm_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

FILE: hdl/third_order_iir_plant_model.sv
// Third-order IIR plant model in transposed direct form II: y = b0*x + s0, then
// the three 48-bit state words are updated from b1..b2 and a1..a3 (Q4.14) and y.
// A sample item occupies the block while all 2*FILTER_ORDER+1 coefficient
// products go one per cycle, but for a wait on the output, through a
// single shared 18x32 multiplier; its result is registered in the PH_Y state,
// and the block holds there until the previous result has been taken. A clear
// item zeroes all three state words while idle and gives no result.
// Coefficients are written on cfg_we with cfg_index 0..5 = b0, b1, b2, a1, a2,
// a3; other indexes are ignored. Write them only while the block is idle.
module third_order_iir_plant_model import tiopm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tiopm_sample_if.sink   samples,
    tiopm_result_if.source results,
    input  logic           cfg_we,
    input  cfg_idx_t       cfg_index,
    input  coef_t          cfg_data
);

    coef_bank_t coefs;
    ctrl_t      ctrl;
    logic       in_ready;
    logic       out_valid;
    sample_t    y;
    logic       clip;

    tiopm_coef_regs u_coef_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coefs     (coefs)
    );

    tiopm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_command (samples.command),
        .out_ready  (results.ready),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .ctrl       (ctrl)
    );

    tiopm_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .coefs     (coefs),
        .in_sample (samples.sample_in),
        .y         (y),
        .clip      (clip)
    );

    assign samples.ready      = in_ready;
    assign results.valid      = out_valid;
    assign results.sample_out = y;
    assign results.saturated  = clip;

endmodule

FILE: hdl/tiopm_coef_regs.sv
// Coefficient register bank written through the plain configuration port.
// Depends on tiopm_pkg.
module tiopm_coef_regs import tiopm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_idx_t   cfg_index,
    input  coef_t      cfg_data,
    output coef_bank_t coefs
);

    coef_bank_t coefs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= COEF_RESET;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            coefs_reg[cfg_index] <= cfg_data;
        end
    end

    assign coefs = coefs_reg;

endmodule

FILE: hdl/tiopm_mul.sv
// Shared signed 18x32 multiplier with a registered full-width product.
// Depends on tiopm_pkg.
module tiopm_mul import tiopm_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  coef_t   coef,
    input  sample_t operand,
    output prod_t   prod
);

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= coef * operand;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/tiopm_ctrl.sv
// Sequencer of the plant model: walks one sample item through the shared
// multiplier and owns both handshakes. Depends on tiopm_pkg.
module tiopm_ctrl import tiopm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_command,
    input  logic  out_ready,
    output logic  in_ready,
    output logic  out_valid,
    output ctrl_t ctrl
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_Y    = 2'd1;
    localparam logic [1:0] PH_B    = 2'd2;
    localparam logic [1:0] PH_A    = 2'd3;

    logic [1:0] phase_reg, phase_next;
    tap_t       tap_reg, tap_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;
    logic       last_tap;

    assign accept   = in_valid && (phase_reg == PH_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign last_tap = (tap_reg == TAP_W'(FILTER_ORDER - 1));

    always_comb
    begin
        ctrl           = '0;
        ctrl.tap       = tap_reg;
        ctrl.last_tap  = last_tap;
        ctrl.op_sel    = OPS_X;
        phase_next     = phase_reg;
        tap_next       = tap_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    if (in_command)
                    begin
                        ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        // Start b0*x straight from the input payload.
                        ctrl.load_x = 1'b1;
                        ctrl.mul_en = 1'b1;
                        ctrl.op_sel = OPS_IN;
                        ctrl.coef_k = '0;
                        phase_next  = PH_Y;
                    end
                end
            end
            PH_Y:
            begin
                // The result register doubles as the fed-back y, so wait for it.
                if (out_free)
                begin
                    ctrl.write_y   = 1'b1;
                    ctrl.mul_en    = 1'b1;
                    ctrl.op_sel    = OPS_X;
                    ctrl.coef_k    = K_W'(1);
                    out_valid_next = 1'b1;
                    tap_next       = '0;
                    phase_next     = PH_B;
                end
            end
            PH_B:
            begin
                ctrl.write_acc = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.op_sel    = OPS_Y;
                ctrl.coef_is_a = 1'b1;
                ctrl.coef_k    = K_W'(tap_reg) + K_W'(1);
                phase_next     = PH_A;
            end
            PH_A:
            begin
                ctrl.write_state = 1'b1;
                if (last_tap)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    ctrl.mul_en = 1'b1;
                    ctrl.op_sel = OPS_X;
                    ctrl.coef_k = K_W'(tap_reg) + K_W'(2);
                    tap_next    = tap_reg + TAP_W'(1);
                    phase_next  = PH_B;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (phase_reg == PH_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/tiopm_dpath.sv
// Datapath of the plant model: operand and coefficient selection, rounding,
// accumulation, saturation and the delay line. Depends on tiopm_pkg, tiopm_mul.
module tiopm_dpath import tiopm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_t      ctrl,
    input  coef_bank_t coefs,
    input  sample_t    in_sample,
    output sample_t    y,
    output logic       clip
);

    function automatic coef_t pick_coef(coef_bank_t bank, logic is_a, k_t k);
        coef_t c;
        c = '0;
        if (!is_a)
        begin
            if (k == K_W'(0))
                c = bank[REG_B0];
            else if (k == K_W'(1))
                c = bank[REG_B1];
            else if ((FILTER_ORDER >= 2) && (k == K_W'(2)))
                c = bank[REG_B2];
        end
        else
        begin
            if (k == K_W'(1))
                c = bank[REG_A1];
            else if ((FILTER_ORDER >= 2) && (k == K_W'(2)))
                c = bank[REG_A2];
            else if ((FILTER_ORDER >= 3) && (k == K_W'(3)))
                c = bank[REG_A3];
        end
        return c;
    endfunction

    sample_t x_reg;
    sample_t y_reg;
    logic    clip_reg;
    acc_t    acc_reg;
    state_t  state_reg [FILTER_ORDER];

    coef_t   mul_coef;
    sample_t mul_operand;
    prod_t   prod;
    rnd_t    rnd;
    acc_t    raw;
    logic    y_fits;
    sample_t y_val;
    tap_t    nxt_idx;
    state_t  nxt;
    acc_t    acc_in;
    diff_t   diff;
    logic    s_fits;
    state_t  s_val;

    assign mul_coef = pick_coef(coefs, ctrl.coef_is_a, ctrl.coef_k);

    always_comb
    begin
        unique case (ctrl.op_sel)
            OPS_IN:  mul_operand = in_sample;
            OPS_X:   mul_operand = x_reg;
            OPS_Y:   mul_operand = y_reg;
            default: mul_operand = x_reg;
        endcase
    end

    tiopm_mul u_mul
    (
        .clk     (clk),
        .en      (ctrl.mul_en),
        .coef    (mul_coef),
        .operand (mul_operand),
        .prod    (prod)
    );

    // Round half up: floor(p / 2^14) plus the bit just below the cut.
    assign rnd = $signed(prod[PROD_W-1:RND_SHIFT])
               + $signed({{(RND_W-1){1'b0}}, prod[RND_SHIFT-1]});

    assign raw    = acc_t'(rnd) + acc_t'(state_reg[0]);
    assign y_fits = (&raw[ACC_W-1:SAMPLE_W-1]) || !(|raw[ACC_W-1:SAMPLE_W-1]);
    assign y_val  = y_fits ? raw[SAMPLE_W-1:0] : (raw[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

    // The last tap has no younger state word to fold in.
    assign nxt_idx = ctrl.tap + TAP_W'(1);
    assign nxt     = ctrl.last_tap ? '0 : state_reg[nxt_idx];
    assign acc_in  = acc_t'(rnd) + acc_t'(nxt);

    assign diff   = diff_t'(acc_reg) - diff_t'(rnd);
    assign s_fits = (&diff[DIFF_W-1:STATE_W-1]) || !(|diff[DIFF_W-1:STATE_W-1]);
    assign s_val  = s_fits ? diff[STATE_W-1:0] : (diff[DIFF_W-1] ? STATE_MIN : STATE_MAX);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
        begin
            x_reg <= in_sample;
        end
        if (ctrl.write_y)
        begin
            y_reg    <= y_val;
            clip_reg <= !y_fits;
        end
        if (ctrl.write_acc)
        begin
            acc_reg <= acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (ctrl.write_state)
        begin
            state_reg[ctrl.tap] <= s_val;
        end
    end

    assign y    = y_reg;
    assign clip = clip_reg;

endmodule

FILE: hdl/tiopm_checker.sv
// Port-level checker for the plant model and its bind to the top level.
// Depends on tiopm_pkg and third_order_iir_plant_model_defines.svh.
`include "third_order_iir_plant_model_defines.svh"

module tiopm_checker import tiopm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    in_command,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_sample,
    input logic    out_saturated
);

    logic in_take;
    logic at_rail;

    assign in_take = in_valid && in_ready;
    assign at_rail = (out_sample == SAMPLE_MAX) || (out_sample == SAMPLE_MIN);

    `TIOPM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "result item dropped")
    `TIOPM_ASSERT_NEXT(a_busy_after_sample, in_take && !in_command, !in_ready, "ready after sample")
    `TIOPM_ASSERT_NEXT(a_clear_one_cycle, in_take && in_command, in_ready, "clear not single")
    `TIOPM_ASSERT_NOW(a_clip_at_rail, out_valid && out_saturated, at_rail, "clipped item off rail")

endmodule

bind third_order_iir_plant_model tiopm_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .in_command    (samples.command),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_sample    (results.sample_out),
    .out_saturated (results.saturated)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the third-order IIR plant model: drives sample and clear items and
// coefficient writes, and compares every result with a bit-exact prediction of the filter.
// Depends on tiopm_pkg, tiopm_sample_if, tiopm_result_if and third_order_iir_plant_model.
module testbench;
    import tiopm_pkg::*;

    localparam bit CMD_FILTER = 1'b0;
    localparam bit CMD_CLEAR  = 1'b1;

    localparam coef_t COEF_MAX = 18'sh1FFFF;
    localparam coef_t COEF_MIN = 18'sh20000;
    localparam coef_t PLANT_DEFAULT_COEF [NUM_REGS] = '{
        18'sd1475, 18'sd164, -18'sd1114, -18'sd37519, 18'sd30310, -18'sd8684
    };

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;

    typedef enum int {COEF_DEFAULT, COEF_RANDOM, COEF_EXTREME, COEF_GENTLE, COEF_CORNER}
        coef_mode_t;

    typedef struct packed {
        sample_t value;
        logic    clipped;
    } plant_output_t;

    class plant_response_board;
        coef_t         coef [NUM_REGS];
        longint        delay_line [FILTER_ORDER];
        plant_output_t awaited[$];
        int            mismatches;

        function new();
            foreach (coef[i]) coef[i] = PLANT_DEFAULT_COEF[i];
            foreach (delay_line[i]) delay_line[i] = 0;
            mismatches = 0;
        endfunction

        function void set_coef(cfg_idx_t idx, coef_t val);
            if (idx < NUM_REGS)
                coef[idx] = val;
        endfunction

        // Full product, then round half up into the Q.16 state format.
        static function longint scaled_product(coef_t c, longint v);
            return (longint'(c) * v + 64'sd8192) >>> 14;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function void note_sample(logic command, sample_t x);
            longint        xv;
            longint        raw;
            longint        y;
            longint        ff;
            longint        nxt;
            plant_output_t outcome;
            if (command == CMD_CLEAR)
            begin
                foreach (delay_line[i]) delay_line[i] = 0;
                return;
            end
            xv  = longint'(x);
            raw = scaled_product(coef[REG_B0], xv) + delay_line[0];
            y   = clamp(raw, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
            outcome.value   = sample_t'(y);
            outcome.clipped = (y != raw);
            awaited.push_back(outcome);
            // The clipped output is what feeds back into the delay line.
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                ff  = (i < 2) ? scaled_product(coef[int'(REG_B1) + i], xv) : 0;
                nxt = (i + 1 < FILTER_ORDER) ? delay_line[i + 1] : 0;
                delay_line[i] = clamp(ff + nxt - scaled_product(coef[int'(REG_A1) + i], y),
                                      longint'(STATE_MIN), longint'(STATE_MAX));
            end
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_output(sample_t got, logic got_sat);
            plant_output_t due;
            if (awaited.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d arrived with nothing outstanding", got));
                return;
            end
            due = awaited.pop_front();
            if (got !== due.value)
                flag_mismatch($sformatf("sample_out %0d, predicted %0d", got, due.value));
            if (got_sat !== due.clipped)
                flag_mismatch($sformatf("saturated %b, predicted %b", got_sat, due.clipped));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    coef_t    cfg_data;
    bit       steady_run;

    plant_response_board plant;

    tiopm_sample_if sample_ch ();
    tiopm_result_if result_ch ();

    third_order_iir_plant_model DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_ch.ready <= steady_run || ($urandom_range(99) >= 22);
    end

    // A result taken at the same edge as a new item belongs to an older item,
    // so it is checked before the new item updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                plant.check_output(result_ch.sample_out, result_ch.saturated);
            if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
                plant.note_sample(sample_ch.command, sample_ch.sample_in);
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5, 6:    return sample_t'(int'($urandom_range(1 << 21)) - (1 << 20));
            7:          return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            default:    return sample_t'(int'($urandom_range(4)) - 2);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken,
    // leaving valid high so a following item can go out back to back.
    task automatic send_item(bit command, sample_t x);
        if (!steady_run && $urandom_range(99) < 22)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < 22)
                @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.command   <= command;
        sample_ch.sample_in <= x;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (plant.awaited.size() != 0)
            @(negedge clk);
        // A trailing clear produces nothing to wait for, so allow the block's latency.
        repeat (12) @(negedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, coef_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        plant.set_coef(idx, val);
        @(negedge clk);
    endtask

    task automatic program_coefs(coef_mode_t mode);
        coef_t val;
        for (int r = 0; r < NUM_REGS; r++)
        begin
            case (mode)
                COEF_DEFAULT: val = PLANT_DEFAULT_COEF[r];
                COEF_RANDOM:  val = coef_t'($urandom);
                COEF_EXTREME:
                    case ($urandom_range(2))
                        0:       val = COEF_MAX;
                        1:       val = COEF_MIN;
                        default: val = '0;
                    endcase
                COEF_GENTLE:  val = coef_t'(int'($urandom_range(8192)) - 4096);
                default:      val = (r % 2 == 0) ? COEF_MAX : COEF_MIN;
            endcase
            write_register(cfg_idx_t'(r), val);
        end
        // An index past the last register must not disturb any coefficient.
        write_register(cfg_idx_t'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)),
                       coef_t'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int hold_at;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.command   = CMD_FILTER;
        sample_ch.sample_in = '0;
        result_ch.ready     = 1'b0;
        steady_run          = 1'b0;
        plant               = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-on coefficients: small steps, full-scale steps, and a clear
        // whose sample field carries a value that must be ignored.
        send_item(CMD_FILTER, '0);
        send_item(CMD_FILTER, sample_t'(1));
        send_item(CMD_FILTER, sample_t'(-1));
        repeat (3) send_item(CMD_FILTER, SAMPLE_MAX);
        send_item(CMD_FILTER, SAMPLE_MIN);
        send_item(CMD_CLEAR, SAMPLE_MAX);
        send_item(CMD_FILTER, sample_t'(65536));
        settle();

        // Full-scale coefficients drive the output into clipping both ways.
        program_coefs(COEF_CORNER);
        send_item(CMD_FILTER, SAMPLE_MAX);
        send_item(CMD_FILTER, SAMPLE_MIN);
        repeat (3) send_item(CMD_FILTER, '0);
        send_item(CMD_CLEAR, pick_sample());
        send_item(CMD_FILTER, '0);
        send_item(CMD_FILTER, sample_t'(1));
        send_item(CMD_FILTER, sample_t'(-1));

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            steady_run = (p == 5);
            program_coefs(coef_mode_t'(p % 4));
            hold_at = $urandom_range(110, 10);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == hold_at)
                    settle();
                if ($urandom_range(99) < 6)
                    send_item(CMD_CLEAR, pick_sample());
                else
                    send_item(CMD_FILTER, pick_sample());
            end
        end
        settle();

        if (plant.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
